[rtl/core/icf_pkg.sv]
// Shared types, widths, constants and the arctangent table of the IMU
// complementary filter. No dependencies; every other file of the block uses it.

package icf_pkg;

  // Field widths
  localparam int InW      = 16;
  localparam int AngW     = 24;
  localparam int GainW    = 16;
  localparam int ForceW   = 17;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 17;

  // CORDIC sizing: iteration count, table depth, operand and angle widths
  localparam int CordicSteps = 16;
  localparam int AtanN       = 24;
  localparam int StepW       = $clog2(AtanN);
  localparam int AtanW       = 23;
  localparam int CordicScale = 14;
  localparam int CW          = 33;
  localparam int ZW          = 27;
  localparam int AccW        = ZW - 8;

  // Shared multiplier and angle adder
  localparam int MulAW = 26;
  localparam int MulBW = 18;
  localparam int ProdW = MulAW + MulBW;
  localparam int SumW  = ProdW + 1;
  localparam int WgtW  = GainW + 1;

  typedef logic signed [InW-1:0]   smp_t;
  typedef logic signed [AngW-1:0]  ang_t;
  typedef logic signed [MulAW-1:0] mul_a_t;
  typedef logic signed [MulBW-1:0] mul_b_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [CW-1:0]    cw_t;
  typedef logic signed [ZW-1:0]    z_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic [StepW-1:0]        step_t;
  typedef logic [ForceW-1:0]       force_t;
  typedef logic [GainW-1:0]        gain_t;
  typedef logic [WgtW-1:0]         wgt_t;
  typedef logic [AtanW-1:0]        atan_t;

  localparam sum_t  SumAngMax  = sum_t'(8388607);
  localparam sum_t  SumAngMin  = sum_t'(-8388608);
  localparam prod_t RndGyro    = prod_t'(128);
  localparam prod_t RndBlend   = prod_t'(32768);
  localparam z_t    Z180       = z_t'(180 * 65536);
  localparam z_t    ZRnd       = z_t'(128);
  localparam step_t CordicLast = step_t'(CordicSteps - 1);
  localparam wgt_t  WgtOne     = wgt_t'(65536);

  typedef struct packed {
    gain_t  gyro_gain;
    gain_t  blend_alpha;
    force_t force_low;
    force_t force_high;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    gyro_gain:   gain_t'(5243),
    blend_alpha: gain_t'(64225),
    force_low:   force_t'(8192),
    force_high:  force_t'(32768)
  };

  typedef struct packed {
    smp_t accel_x;
    smp_t accel_y;
    smp_t accel_z;
    smp_t gyro_x;
    smp_t gyro_y;
    smp_t gyro_z;
  } sample_t;

  typedef struct packed {
    ang_t pitch_out;
    ang_t roll_out;
    ang_t yaw_out;
    logic accel_applied;
  } result_t;

  typedef enum logic {
    AXIS_PITCH,
    AXIS_ROLL
  } axis_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_GX,
    MUL_GY,
    MUL_GZ,
    MUL_BLEND
  } mul_sel_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_PITCH_ADD,
    UPD_ROLL_SUB,
    UPD_YAW_ADD,
    UPD_BLEND
  } upd_e;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    upd_e     upd;
    axis_e    cz_axis;
    logic     cz_init;
    logic     cz_iter;
    logic     cz_fin;
    logic     load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic force_ok;
    logic cz_last;
  } dp_sts_t;

  // Top level to controller and back
  typedef struct packed {
    logic in_valid;
    logic out_ready;
  } hs_req_t;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
  } hs_rsp_t;

  // atan(2^-i) in degrees times 65536
  function automatic atan_t atan_deg(input step_t idx);
    atan_t v;
    unique case (idx)
      0:  v = atan_t'(2949120);
      1:  v = atan_t'(1740967);
      2:  v = atan_t'(919879);
      3:  v = atan_t'(466945);
      4:  v = atan_t'(234379);
      5:  v = atan_t'(117304);
      6:  v = atan_t'(58666);
      7:  v = atan_t'(29335);
      8:  v = atan_t'(14668);
      9:  v = atan_t'(7334);
      10: v = atan_t'(3667);
      11: v = atan_t'(1833);
      12: v = atan_t'(917);
      13: v = atan_t'(458);
      14: v = atan_t'(229);
      15: v = atan_t'(115);
      16: v = atan_t'(57);
      17: v = atan_t'(29);
      18: v = atan_t'(14);
      19: v = atan_t'(7);
      20: v = atan_t'(4);
      21: v = atan_t'(2);
      22: v = atan_t'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/icf_if.sv]
// Handshake channels of the IMU complementary filter: sample in, result out,
// register write. Depends on icf_pkg for field widths.

interface icf_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [icf_pkg::InW-1:0]  accel_x;
  logic signed [icf_pkg::InW-1:0]  accel_y;
  logic signed [icf_pkg::InW-1:0]  accel_z;
  logic signed [icf_pkg::InW-1:0]  gyro_x;
  logic signed [icf_pkg::InW-1:0]  gyro_y;
  logic signed [icf_pkg::InW-1:0]  gyro_z;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                output ready);
endinterface

interface icf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [icf_pkg::AngW-1:0]  pitch_out;
  logic signed [icf_pkg::AngW-1:0]  roll_out;
  logic signed [icf_pkg::AngW-1:0]  yaw_out;
  logic                             accel_applied;

  modport source (output valid, pitch_out, roll_out, yaw_out, accel_applied,
                  input ready);
  modport sink (input valid, pitch_out, roll_out, yaw_out, accel_applied,
                output ready);
endinterface

interface icf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [icf_pkg::CfgIdxW-1:0]    index;
  logic [icf_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/icf_dp.sv]
// Datapath of the IMU complementary filter: sample register, shared multiplier,
// saturating angle adder, iterative CORDIC atan2 and result register. Uses icf_pkg.

module icf_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  icf_pkg::dp_cmd_t  cmd_i,
  input  icf_pkg::cfg_t     cfg_i,
  input  icf_pkg::sample_t  sample_i,
  output icf_pkg::dp_sts_t  sts_o,
  output icf_pkg::result_t  result_o
);

  icf_pkg::sample_t sample_q;

  icf_pkg::ang_t    pitch_q, roll_q, yaw_q;
  icf_pkg::prod_t   prod_q;
  icf_pkg::cw_t     cx_q, cy_q;
  icf_pkg::z_t      cz_q;
  logic             cz_zero_q;
  icf_pkg::step_t   step_q;
  icf_pkg::acc_t    acc_q;
  icf_pkg::result_t result_q;

  icf_pkg::mul_a_t  mul_a;
  icf_pkg::mul_b_t  mul_b;
  icf_pkg::mul_b_t  gain_b;
  icf_pkg::mul_b_t  wgt_b;
  icf_pkg::wgt_t    wgt;
  icf_pkg::ang_t    blend_ang;
  icf_pkg::prod_t   rnd_g, rnd_b, dlt_g, dlt_b, dlt;
  icf_pkg::ang_t    base;
  logic             sub;
  icf_pkg::sum_t    sum;
  icf_pkg::ang_t    upd_val;

  icf_pkg::force_t  abs_x, abs_y, abs_z, force_sum;

  icf_pkg::smp_t    op_y, op_x;
  logic signed [icf_pkg::InW:0] ext_x, ext_y, neg_x, neg_y;
  logic             op_neg, op_zero;
  icf_pkg::cw_t     xs, ys;
  logic             rot_neg;
  icf_pkg::z_t      atan_z, z_rnd;

  function automatic icf_pkg::force_t abs_smp(input icf_pkg::smp_t v);
    logic signed [icf_pkg::InW:0] e;
    e = {v[icf_pkg::InW-1], v};
    return e[icf_pkg::InW] ? icf_pkg::force_t'(-e) : icf_pkg::force_t'(e);
  endfunction

  function automatic icf_pkg::ang_t sat_ang(input icf_pkg::sum_t v);
    icf_pkg::ang_t r;
    if (v > icf_pkg::SumAngMax) begin
      r = icf_pkg::ang_t'(icf_pkg::SumAngMax);
    end else if (v < icf_pkg::SumAngMin) begin
      r = icf_pkg::ang_t'(icf_pkg::SumAngMin);
    end else begin
      r = icf_pkg::ang_t'(v);
    end
    return r;
  endfunction

  // Accelerometer magnitude gate
  assign abs_x     = abs_smp(sample_q.accel_x);
  assign abs_y     = abs_smp(sample_q.accel_y);
  assign abs_z     = abs_smp(sample_q.accel_z);
  assign force_sum = abs_x + abs_y + abs_z;

  assign sts_o.force_ok = (force_sum > cfg_i.force_low) && (force_sum < cfg_i.force_high);
  assign sts_o.cz_last  = (step_q == icf_pkg::CordicLast);

  // Shared multiplier operands
  assign blend_ang = (cmd_i.cz_axis == icf_pkg::AXIS_PITCH) ? pitch_q : roll_q;
  assign gain_b    = icf_pkg::mul_b_t'($signed({1'b0, cfg_i.gyro_gain}));
  assign wgt       = icf_pkg::WgtOne - {1'b0, cfg_i.blend_alpha};
  assign wgt_b     = icf_pkg::mul_b_t'($signed({1'b0, wgt}));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      icf_pkg::MUL_GX: begin
        mul_a = icf_pkg::mul_a_t'(sample_q.gyro_x);
        mul_b = gain_b;
      end
      icf_pkg::MUL_GY: begin
        mul_a = icf_pkg::mul_a_t'(sample_q.gyro_y);
        mul_b = gain_b;
      end
      icf_pkg::MUL_GZ: begin
        mul_a = icf_pkg::mul_a_t'(sample_q.gyro_z);
        mul_b = gain_b;
      end
      icf_pkg::MUL_BLEND: begin
        // alpha*a + (1-alpha)*c == a + (1-alpha)*(c-a), exactly
        mul_a = icf_pkg::mul_a_t'(acc_q) - icf_pkg::mul_a_t'(blend_ang);
        mul_b = wgt_b;
      end
      default: ;
    endcase
  end

  // Rounded deltas from the registered product
  assign rnd_g = prod_q + icf_pkg::RndGyro;
  assign rnd_b = prod_q + icf_pkg::RndBlend;
  assign dlt_g = rnd_g >>> 8;
  assign dlt_b = rnd_b >>> 16;

  always_comb begin
    base = pitch_q;
    dlt  = dlt_g;
    sub  = 1'b0;
    unique case (cmd_i.upd)
      icf_pkg::UPD_PITCH_ADD: base = pitch_q;
      icf_pkg::UPD_ROLL_SUB: begin
        base = roll_q;
        sub  = 1'b1;
      end
      icf_pkg::UPD_YAW_ADD: base = yaw_q;
      icf_pkg::UPD_BLEND: begin
        base = blend_ang;
        dlt  = dlt_b;
      end
      default: ;
    endcase
  end

  assign sum     = sub ? (icf_pkg::sum_t'(base) - icf_pkg::sum_t'(dlt))
                       : (icf_pkg::sum_t'(base) + icf_pkg::sum_t'(dlt));
  assign upd_val = sat_ang(sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      roll_q  <= '0;
      yaw_q   <= '0;
    end else begin
      unique case (cmd_i.upd)
        icf_pkg::UPD_PITCH_ADD: pitch_q <= upd_val;
        icf_pkg::UPD_ROLL_SUB:  roll_q  <= upd_val;
        icf_pkg::UPD_YAW_ADD:   yaw_q   <= upd_val;
        icf_pkg::UPD_BLEND: begin
          if (cmd_i.cz_axis == icf_pkg::AXIS_PITCH) begin
            pitch_q <= upd_val;
          end else begin
            roll_q <= upd_val;
          end
        end
        default: ;
      endcase
    end
  end

  // CORDIC operand set-up: fold the left half plane, scale by 2^14
  assign op_y    = (cmd_i.cz_axis == icf_pkg::AXIS_PITCH) ? sample_q.accel_y
                                                          : sample_q.accel_x;
  assign op_x    = sample_q.accel_z;
  assign ext_x   = {op_x[icf_pkg::InW-1], op_x};
  assign ext_y   = {op_y[icf_pkg::InW-1], op_y};
  assign neg_x   = -ext_x;
  assign neg_y   = -ext_y;
  assign op_neg  = op_x[icf_pkg::InW-1];
  assign op_zero = (op_x == '0) && (op_y == '0);

  // One micro-rotation per cycle
  assign xs      = cx_q >>> step_q;
  assign ys      = cy_q >>> step_q;
  assign rot_neg = !cy_q[icf_pkg::CW-1] && (cy_q != '0);
  assign atan_z  = $signed({{(icf_pkg::ZW - icf_pkg::AtanW){1'b0}},
                            icf_pkg::atan_deg(step_q)});
  assign z_rnd   = cz_q + icf_pkg::ZRnd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sample_q <= sample_i;
    end
    prod_q <= icf_pkg::prod_t'(mul_a) * icf_pkg::prod_t'(mul_b);
    if (cmd_i.cz_init) begin
      cx_q      <= (op_neg ? icf_pkg::cw_t'(neg_x) : icf_pkg::cw_t'(ext_x))
                   <<< icf_pkg::CordicScale;
      cy_q      <= (op_neg ? icf_pkg::cw_t'(neg_y) : icf_pkg::cw_t'(ext_y))
                   <<< icf_pkg::CordicScale;
      cz_q      <= op_neg ? (op_y[icf_pkg::InW-1] ? -icf_pkg::Z180 : icf_pkg::Z180) : '0;
      cz_zero_q <= op_zero;
      step_q    <= '0;
    end else if (cmd_i.cz_iter) begin
      if (rot_neg) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atan_z;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atan_z;
      end
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.cz_fin) begin
      acc_q <= cz_zero_q ? '0 : icf_pkg::acc_t'(z_rnd >>> 8);
    end
    if (cmd_i.load_out) begin
      result_q.pitch_out     <= pitch_q;
      result_q.roll_out      <= roll_q;
      result_q.yaw_out       <= yaw_q;
      result_q.accel_applied <= sts_o.force_ok;
    end
  end

  assign result_o = result_q;

endmodule

[rtl/core/icf_ctrl.sv]
// Sequencer of the IMU complementary filter: walks gyro update and, with the
// force gate open, two CORDIC passes and blends; owns the channel handshakes. Uses icf_pkg.

module icf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  icf_pkg::hs_req_t  hs_i,
  input  icf_pkg::dp_sts_t  sts_i,
  output icf_pkg::hs_rsp_t  hs_o,
  output icf_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GX,
    S_GY,
    S_GZ,
    S_GADD,
    S_CZ_INIT,
    S_CZ_ITER,
    S_CZ_FIN,
    S_BL_MUL,
    S_BL_ADD,
    S_DONE
  } state_e;

  state_e         state_q;
  icf_pkg::axis_e axis_q;
  logic           out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = icf_pkg::MUL_NONE;
    cmd_o.upd      = icf_pkg::UPD_NONE;
    cmd_o.cz_axis  = axis_q;
    unique case (state_q)
      S_IDLE:    cmd_o.load_in = hs_i.in_valid;
      S_GX:      cmd_o.mul_sel = icf_pkg::MUL_GX;
      S_GY: begin
        cmd_o.mul_sel = icf_pkg::MUL_GY;
        cmd_o.upd     = icf_pkg::UPD_PITCH_ADD;
      end
      S_GZ: begin
        cmd_o.mul_sel = icf_pkg::MUL_GZ;
        cmd_o.upd     = icf_pkg::UPD_ROLL_SUB;
      end
      S_GADD:    cmd_o.upd      = icf_pkg::UPD_YAW_ADD;
      S_CZ_INIT: cmd_o.cz_init  = 1'b1;
      S_CZ_ITER: cmd_o.cz_iter  = 1'b1;
      S_CZ_FIN:  cmd_o.cz_fin   = 1'b1;
      S_BL_MUL:  cmd_o.mul_sel  = icf_pkg::MUL_BLEND;
      S_BL_ADD:  cmd_o.upd      = icf_pkg::UPD_BLEND;
      S_DONE:    cmd_o.load_out = !out_valid_q || hs_i.out_ready;
      default: ;
    endcase
  end

  assign hs_o.in_ready  = (state_q == S_IDLE);
  assign hs_o.out_valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= icf_pkg::AXIS_PITCH;
      out_valid_q <= 1'b0;
    end else begin
      // hold the result until taken, refill as it leaves
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (hs_i.out_ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (hs_i.in_valid) begin
            state_q <= S_GX;
          end
        end
        S_GX:   state_q <= S_GY;
        S_GY:   state_q <= S_GZ;
        S_GZ:   state_q <= S_GADD;
        S_GADD: begin
          axis_q  <= icf_pkg::AXIS_PITCH;
          state_q <= sts_i.force_ok ? S_CZ_INIT : S_DONE;
        end
        S_CZ_INIT: state_q <= S_CZ_ITER;
        S_CZ_ITER: begin
          if (sts_i.cz_last) begin
            state_q <= S_CZ_FIN;
          end
        end
        S_CZ_FIN:  state_q <= S_BL_MUL;
        S_BL_MUL:  state_q <= S_BL_ADD;
        S_BL_ADD: begin
          if (axis_q == icf_pkg::AXIS_PITCH) begin
            axis_q  <= icf_pkg::AXIS_ROLL;
            state_q <= S_CZ_INIT;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd_o.load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/imu_complementary_filter_unit.sv]
// Top level of the IMU complementary filter: register file, controller and
// datapath. Depends on icf_pkg, icf_if, icf_ctrl and icf_dp.
//
//   channel  direction  payload                                        accepted when
//   in_i     sink       accel_x/y/z, gyro_x/y/z (16 b signed)          valid & ready
//   out_o    source     pitch/roll/yaw_out (24 b signed), accel_applied valid & ready
//   cfg_i    sink       index (8 b), data (17 b)                        valid & ready
//
// Items: one item at a time; in_i is ready again only once the result is loaded
// into the output register. Only when the accelerometer blend applies does the
// single CORDIC unit run the pitch and roll atan2, in turn.
// Reset: rst_ni clears angles to zero and loads the register defaults.
// Stalls: a finished result waits in the output register while a new item is taken;
// only a second finished result waits for out_o.ready. cfg_i is always ready.

module imu_complementary_filter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  icf_in_if.sink     in_i,
  icf_out_if.source  out_o,
  icf_cfg_if.sink    cfg_i
);

  typedef enum logic [icf_pkg::CfgIdxW-1:0] {
    REG_GYRO_GAIN,
    REG_BLEND_ALPHA,
    REG_FORCE_LOW,
    REG_FORCE_HIGH
  } cfg_reg_e;

  icf_pkg::cfg_t    cfg_q;
  icf_pkg::sample_t sample;
  icf_pkg::result_t result;
  icf_pkg::hs_req_t hs_req;
  icf_pkg::hs_rsp_t hs_rsp;
  icf_pkg::dp_cmd_t dp_cmd;
  icf_pkg::dp_sts_t dp_sts;

  // Register file: writes land at once; indices beyond the list drop
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= icf_pkg::CfgReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_GYRO_GAIN:   cfg_q.gyro_gain   <= cfg_i.data[icf_pkg::GainW-1:0];
        REG_BLEND_ALPHA: cfg_q.blend_alpha <= cfg_i.data[icf_pkg::GainW-1:0];
        REG_FORCE_LOW:   cfg_q.force_low   <= cfg_i.data[icf_pkg::ForceW-1:0];
        REG_FORCE_HIGH:  cfg_q.force_high  <= cfg_i.data[icf_pkg::ForceW-1:0];
        default: ;
      endcase
    end
  end

  // Pack the sample channel for the datapath
  assign sample.accel_x = in_i.accel_x;
  assign sample.accel_y = in_i.accel_y;
  assign sample.accel_z = in_i.accel_z;
  assign sample.gyro_x  = in_i.gyro_x;
  assign sample.gyro_y  = in_i.gyro_y;
  assign sample.gyro_z  = in_i.gyro_z;

  assign hs_req.in_valid  = in_i.valid;
  assign hs_req.out_ready = out_o.ready;
  assign in_i.ready       = hs_rsp.in_ready;
  assign out_o.valid      = hs_rsp.out_valid;

  icf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hs_i   (hs_req),
    .sts_i  (dp_sts),
    .hs_o   (hs_rsp),
    .cmd_o  (dp_cmd)
  );

  icf_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .cfg_i    (cfg_q),
    .sample_i (sample),
    .sts_o    (dp_sts),
    .result_o (result)
  );

  // Unpack the result register onto the output channel
  assign out_o.pitch_out     = result.pitch_out;
  assign out_o.roll_out      = result.roll_out;
  assign out_o.yaw_out       = result.yaw_out;
  assign out_o.accel_applied = result.accel_applied;

`ifndef ASSERT_OFF
  // An accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready straight after an accepted item");

  // The result register is never overwritten while an item still waits in it
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.load_out |-> (!out_o.valid || out_o.ready))
    else $error("result register loaded over a waiting item");

  // A result appears only through a load of the result register
  a_valid_from_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(dp_cmd.load_out))
    else $error("output valid rose without a result load");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for imu_complementary_filter_unit: drives IMU samples,
// predicts the attitude angles and checks every result. Depends on icf_pkg and icf_if.

module tb;
  import icf_pkg::*;

  // Register map of the configuration channel
  localparam int RegGyroGain   = 0;
  localparam int RegBlendAlpha = 1;
  localparam int RegForceLow   = 2;
  localparam int RegForceHigh  = 3;
  localparam int RegFirstFree  = 4;
  localparam int RegLastIndex  = (1 << CfgIdxW) - 1;

  localparam int     HalfPeriod  = 5;
  localparam int     ResetCycles = 8;
  // Longest item (both atan2 passes) plus margin for the output register
  localparam int     DrainCycles = 2 * (2 * (CordicSteps + 4) + 6);
  localparam longint AngMax      = 64'sd8388607;
  localparam longint AngMin      = -64'sd8388608;
  localparam longint Deg180      = 64'sd180 * 64'sd65536;

  logic clk_i = 1'b0;
  logic rst_ni;

  icf_in_if  sample_if ();
  icf_out_if attitude_if ();
  icf_cfg_if reg_if ();

  imu_complementary_filter_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_if),
    .out_o  (attitude_if),
    .cfg_i  (reg_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Shadow registers and angle state of the filter
  gain_t  gain_reg  = CfgReset.gyro_gain;
  gain_t  alpha_reg = CfgReset.blend_alpha;
  force_t low_reg   = CfgReset.force_low;
  force_t high_reg  = CfgReset.force_high;
  longint pitch_acc = 0;
  longint roll_acc  = 0;
  longint yaw_acc   = 0;

  // atan(2^-i) in degrees times 65536
  longint atan_step [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  sample_t sample_queue [$];
  result_t attitude_expected [$];
  sample_t offered_sample;
  int      src_idle_pct   = 0;
  int      sink_stall_pct = 0;
  int      mismatch_count = 0;

  function automatic longint clamp_angle(input longint v);
    if (v > AngMax) return AngMax;
    if (v < AngMin) return AngMin;
    return v;
  endfunction

  // Vectoring CORDIC atan2 in degrees times 256
  function automatic longint tilt_atan2(input longint y_in, input longint x_in);
    longint x, y, z, xs, ys;
    int     i;
    x = x_in;
    y = y_in;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // Left half plane: fold the vector over and start from +/-180 degrees
    if (x < 0) begin
      z = (y >= 0) ? Deg180 : -Deg180;
      x = -x;
      y = -y;
    end
    x = x * 16384;
    y = y * 16384;
    for (i = 0; i < CordicSteps && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[i];
      end
    end
    return (z + 128) >>> 8;
  endfunction

  function automatic longint mix_angle(input longint angle, input longint acc);
    longint a;
    a = longint'(alpha_reg);
    return clamp_angle((a * angle + (65536 - a) * acc + 32768) >>> 16);
  endfunction

  // Advance the angle state by one sample and return the result it must produce
  function automatic result_t attitude_update(input sample_t s);
    longint  ax, ay, az, g, force_sum;
    result_t r;
    ax = longint'($signed(s.accel_x));
    ay = longint'($signed(s.accel_y));
    az = longint'($signed(s.accel_z));
    g  = longint'(gain_reg);
    pitch_acc = clamp_angle(pitch_acc + ((longint'($signed(s.gyro_x)) * g + 128) >>> 8));
    roll_acc  = clamp_angle(roll_acc  - ((longint'($signed(s.gyro_y)) * g + 128) >>> 8));
    yaw_acc   = clamp_angle(yaw_acc   + ((longint'($signed(s.gyro_z)) * g + 128) >>> 8));
    force_sum = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
    r.accel_applied = 1'b0;
    // Blend only strictly inside the window; equal or crossed bounds never blend
    if (force_sum > longint'(low_reg) && force_sum < longint'(high_reg)) begin
      pitch_acc = mix_angle(pitch_acc, tilt_atan2(ay, az));
      roll_acc  = mix_angle(roll_acc, tilt_atan2(ax, az));
      r.accel_applied = 1'b1;
    end
    r.pitch_out = ang_t'(pitch_acc);
    r.roll_out  = ang_t'(roll_acc);
    r.yaw_out   = ang_t'(yaw_acc);
    return r;
  endfunction

  // Sample driver: offer the next queued item, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
    end else if (!sample_if.valid || sample_if.ready) begin
      if (sample_if.valid) begin
        attitude_expected.push_back(attitude_update(offered_sample));
      end
      if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        offered_sample = sample_queue.pop_front();
        sample_if.valid   <= 1'b1;
        sample_if.accel_x <= offered_sample.accel_x;
        sample_if.accel_y <= offered_sample.accel_y;
        sample_if.accel_z <= offered_sample.accel_z;
        sample_if.gyro_x  <= offered_sample.gyro_x;
        sample_if.gyro_y  <= offered_sample.gyro_y;
        sample_if.gyro_z  <= offered_sample.gyro_z;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each accepted item with the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      attitude_if.ready <= 1'b0;
    end else begin
      if (attitude_if.valid && attitude_if.ready) begin
        if (attitude_expected.size() == 0) begin
          $error("result item with no prediction waiting");
          mismatch_count++;
        end else begin
          want = attitude_expected.pop_front();
          if (attitude_if.pitch_out !== want.pitch_out) begin
            $error("pitch_out: expected %0d, got %0d", want.pitch_out, attitude_if.pitch_out);
            mismatch_count++;
          end
          if (attitude_if.roll_out !== want.roll_out) begin
            $error("roll_out: expected %0d, got %0d", want.roll_out, attitude_if.roll_out);
            mismatch_count++;
          end
          if (attitude_if.yaw_out !== want.yaw_out) begin
            $error("yaw_out: expected %0d, got %0d", want.yaw_out, attitude_if.yaw_out);
            mismatch_count++;
          end
          if (attitude_if.accel_applied !== want.accel_applied) begin
            $error("accel_applied: expected %0d, got %0d", want.accel_applied,
                   attitude_if.accel_applied);
            mismatch_count++;
          end
        end
      end
      attitude_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Write one register and mirror it into the shadow copy; values are masked
  // to the register width as the hardware does
  task automatic write_reg(input int idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    reg_if.valid <= 1'b1;
    reg_if.index <= CfgIdxW'(idx);
    reg_if.data  <= val;
    do @(posedge clk_i); while (!reg_if.ready);
    reg_if.valid <= 1'b0;
    case (idx)
      RegGyroGain:   gain_reg  = gain_t'(val);
      RegBlendAlpha: alpha_reg = gain_t'(val);
      RegForceLow:   low_reg   = force_t'(val);
      RegForceHigh:  high_reg  = force_t'(val);
      default: ;
    endcase
  endtask

  // Hold until every item is taken and every result is back, then let the block settle
  task automatic settle();
    while (sample_queue.size() != 0 || sample_if.valid || attitude_expected.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_sample(input int ax, input int ay, input int az,
                             input int gx, input int gy, input int gz);
    sample_t s;
    s.accel_x = smp_t'(ax);
    s.accel_y = smp_t'(ay);
    s.accel_z = smp_t'(az);
    s.gyro_x  = smp_t'(gx);
    s.gyro_y  = smp_t'(gy);
    s.gyro_z  = smp_t'(gz);
    sample_queue.push_back(s);
  endtask

  function automatic smp_t spread(input int unsigned mag);
    return smp_t'(int'($urandom_range(2 * mag)) - int'(mag));
  endfunction

  function automatic smp_t corner();
    case ($urandom_range(4))
      0:       return smp_t'(-32768);
      1:       return smp_t'(32767);
      2:       return smp_t'(0);
      3:       return smp_t'(-1);
      default: return smp_t'(1);
    endcase
  endfunction

  // Mostly plausible tilt vectors with moderate rates, some raw noise,
  // some corner values and some vectors with zeroed axes
  task automatic queue_random(input int n);
    sample_t     s;
    int unsigned kind, mag;
    int          k;
    for (k = 0; k < n; k++) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        case ($urandom_range(3))
          0:       mag = 2000;
          1:       mag = 6000;
          2:       mag = 12000;
          default: mag = 32767;
        endcase
        s.accel_x = spread(mag);
        s.accel_y = spread(mag);
        s.accel_z = spread(mag);
        s.gyro_x  = spread(3000);
        s.gyro_y  = spread(3000);
        s.gyro_z  = spread(3000);
      end else if (kind < 80) begin
        s = sample_t'({$urandom, $urandom, $urandom});
      end else if (kind < 90) begin
        s.accel_x = corner();
        s.accel_y = corner();
        s.accel_z = corner();
        s.gyro_x  = corner();
        s.gyro_y  = corner();
        s.gyro_z  = corner();
      end else begin
        s.accel_x = spread(16000);
        s.accel_y = spread(16000);
        s.accel_z = smp_t'(0);
        if ($urandom_range(1)) s.accel_y = smp_t'(0);
        else s.accel_x = smp_t'(0);
        s.gyro_x = spread(500);
        s.gyro_y = spread(500);
        s.gyro_z = spread(500);
      end
      sample_queue.push_back(s);
    end
  endtask

  initial begin
    // Drive every input to a known value from time zero
    sample_if.valid   = 1'b0;
    sample_if.accel_x = '0;
    sample_if.accel_y = '0;
    sample_if.accel_z = '0;
    sample_if.gyro_x  = '0;
    sample_if.gyro_y  = '0;
    sample_if.gyro_z  = '0;
    attitude_if.ready = 1'b0;
    reg_if.valid      = 1'b0;
    reg_if.index      = '0;
    reg_if.data       = '0;
    rst_ni            = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, no idling: directed corners first
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    push_sample(0, 0, 0, 0, 0, 0);
    // Both operands of the pitch atan2 zero; roll sees +90 degrees
    push_sample(16384, 0, 0, 0, 0, 0);
    push_sample(0, 16384, 0, 0, 0, 0);
    push_sample(0, -16384, 0, 0, 0, 0);
    // Left half plane with y above and below zero, and on the negative axis
    push_sample(1000, 1000, -16384, 0, 0, 0);
    push_sample(-1000, -1000, -16384, 0, 0, 0);
    push_sample(0, 0, -16384, 0, 0, 0);
    push_sample(0, 0, 16384, 0, 0, 0);
    // Force exactly on the lower bound, just above it, just below and on the upper
    push_sample(8192, 0, 0, 0, 0, 0);
    push_sample(8193, 0, 0, 0, 0, 0);
    push_sample(32767, 0, 0, 0, 0, 0);
    push_sample(-32768, 0, 0, 0, 0, 0);
    push_sample(-32768, -32768, -32768, 0, 0, 0);
    push_sample(32767, 32767, 32767, 0, 0, 0);
    push_sample(0, 0, 0, 32767, 32767, 32767);
    push_sample(0, 0, 0, -32768, -32768, -32768);
    push_sample(0, 0, 0, 1, -1, 1);
    push_sample(0, 0, 0, -1, -1, -1);
    push_sample(-12000, 5000, -3000, 700, -900, 1200);
    push_sample(10000, -10000, 10000, -250, 250, -4000);
    queue_random(300);
    settle();

    // Full gain, accelerometer only, window wide open; sender idles
    write_reg(RegGyroGain, 17'h1FFFF);
    write_reg(RegBlendAlpha, 17'h00000);
    write_reg(RegForceLow, 17'h00000);
    write_reg(RegForceHigh, 17'h1FFFF);
    src_idle_pct   = 79;
    sink_stall_pct = 0;
    // Drive the angles into saturation at both ends; zero force never blends
    repeat (3) push_sample(0, 0, 0, 32767, -32768, 32767);
    repeat (3) push_sample(0, 0, 0, -32768, 32767, -32768);
    push_sample(0, 16384, 16384, 32767, 32767, 32767);
    queue_random(150);
    // Pause the sender until every result is back, then carry on
    settle();
    queue_random(150);
    settle();

    // Zero gain, almost angle only, equal bounds: no blend ever; receiver stalls
    write_reg(RegGyroGain, 17'h00000);
    write_reg(RegBlendAlpha, 17'h0FFFF);
    write_reg(RegForceLow, 17'd20000);
    write_reg(RegForceHigh, 17'd20000);
    src_idle_pct   = 0;
    sink_stall_pct = 79;
    queue_random(300);
    settle();

    // Crossed bounds, writes to unused indexes must be dropped; both sides idle
    write_reg(RegGyroGain, 17'd1234);
    write_reg(RegBlendAlpha, 17'd32768);
    write_reg(RegForceLow, 17'd40000);
    write_reg(RegForceHigh, 17'd10000);
    write_reg(RegFirstFree, 17'h1FFFF);
    write_reg(RegLastIndex, 17'h15555);
    src_idle_pct   = 21;
    sink_stall_pct = 21;
    queue_random(300);
    settle();

    // Random settings with a sensible window, no idling
    write_reg(RegGyroGain, CfgDataW'($urandom_range(65535)));
    write_reg(RegBlendAlpha, CfgDataW'($urandom_range(65535)));
    write_reg(RegForceLow, CfgDataW'($urandom_range(20000)));
    write_reg(RegForceHigh, CfgDataW'($urandom_range(98304, 20000)));
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    queue_random(300);
    settle();

    if (mismatch_count == 0) begin
      $display("imu_complementary_filter_unit regression: pass");
    end else begin
      $display("imu_complementary_filter_unit regression: fail");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("imu_complementary_filter_unit regression: fail");
    $finish;
  end

endmodule

[imu_complementary_filter_unit.f]
rtl/core/icf_pkg.sv
rtl/core/icf_if.sv
rtl/core/icf_dp.sv
rtl/core/icf_ctrl.sv
rtl/core/imu_complementary_filter_unit.sv
bench/tb.sv
